FILE: rtl/ptrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrb_pkg
// Shared widths, codes, state encoding and the controller/datapath interface
// structs of the per-thread reduction bank.
// ----------------------------------------------------------------------------
package ptrb_pkg;

	localparam int DATA_W    = 64;
	localparam int HALF_W    = DATA_W / 2;
	localparam int THREAD_W  = 6;
	localparam int KIND_W    = 2;
	localparam int OP_W      = 4;
	localparam int CFG_IDX_W = 2;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_START    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UPDATE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COLLAPSE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;

	// operator codes, unused codes fold as add
	localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
	localparam logic [OP_W-1:0] OP_MUL  = 4'd1;
	localparam logic [OP_W-1:0] OP_OR   = 4'd2;
	localparam logic [OP_W-1:0] OP_AND  = 4'd3;
	localparam logic [OP_W-1:0] OP_XOR  = 4'd4;
	localparam logic [OP_W-1:0] OP_UMIN = 4'd5;
	localparam logic [OP_W-1:0] OP_UMAX = 4'd6;
	localparam logic [OP_W-1:0] OP_SMIN = 4'd7;
	localparam logic [OP_W-1:0] OP_SMAX = 4'd8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OP_SELECT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDENTITY_VALUE = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_U_RD,
		ST_U_WAIT,
		ST_U_WR,
		ST_C_RD,
		ST_C_WAIT,
		ST_C_EX,
		ST_C_DONE
	} state_t;

	typedef enum logic [1:0] {
		WSEL_ZERO,
		WSEL_RELOAD,
		WSEL_RESULT
	} wsel_t;

	typedef struct packed {
		logic  latch;
		logic  idx_clr;
		logic  idx_inc;
		logic  mem_re;
		logic  rd_thread;
		logic  mem_we;
		logic  wr_thread;
		wsel_t wsel;
		logic  collapse;
		logic  acc_load_rd;
		logic  acc_load_res;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic idx_zero;
		logic idx_last;
		logic thread_ok;
	} sts_t;

endpackage

FILE: rtl/ptrb_combine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrb_combine
// Two-step fold unit: operands and 32x32 partial products are registered,
// then the selected operator result is formed from the registered values.
// ----------------------------------------------------------------------------
module ptrb_combine (
	input  logic                         clk,
	input  logic [ptrb_pkg::DATA_W-1:0]  a,
	input  logic [ptrb_pkg::DATA_W-1:0]  b,
	input  logic [ptrb_pkg::OP_W-1:0]    op,
	output logic [ptrb_pkg::DATA_W-1:0]  res
);
	import ptrb_pkg::*;

	logic [DATA_W-1:0] p_ll;
	logic [HALF_W-1:0] p_lh;
	logic [HALF_W-1:0] p_hl;

	logic [DATA_W-1:0] a_s1;
	logic [DATA_W-1:0] b_s1;
	logic [OP_W-1:0]   op_s1;
	logic [DATA_W-1:0] p_ll_s1;
	logic [HALF_W-1:0] p_lh_s1;
	logic [HALF_W-1:0] p_hl_s1;

	// only the low halves of the cross terms reach the low 64 bits
	assign p_ll = DATA_W'(a[HALF_W-1:0]) * DATA_W'(b[HALF_W-1:0]);
	assign p_lh = a[HALF_W-1:0] * b[DATA_W-1:HALF_W];
	assign p_hl = a[DATA_W-1:HALF_W] * b[HALF_W-1:0];

	always_ff @(posedge clk) begin
		a_s1    <= a;
		b_s1    <= b;
		op_s1   <= op;
		p_ll_s1 <= p_ll;
		p_lh_s1 <= p_lh;
		p_hl_s1 <= p_hl;
	end

	always_comb begin
		case (op_s1)
			OP_MUL:  res = p_ll_s1 + {p_lh_s1 + p_hl_s1, {HALF_W{1'b0}}};
			OP_OR:   res = a_s1 | b_s1;
			OP_AND:  res = a_s1 & b_s1;
			OP_XOR:  res = a_s1 ^ b_s1;
			OP_UMIN: res = (a_s1 < b_s1) ? a_s1 : b_s1;
			OP_UMAX: res = (a_s1 > b_s1) ? a_s1 : b_s1;
			OP_SMIN: res = ($signed(a_s1) < $signed(b_s1)) ? a_s1 : b_s1;
			OP_SMAX: res = ($signed(a_s1) > $signed(b_s1)) ? a_s1 : b_s1;
			default: res = a_s1 + b_s1;
		endcase
	end

endmodule

FILE: rtl/ptrb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrb_datapath
// Configuration registers, partials memory, walk counter, fold unit,
// collapse accumulator and result register.
// ----------------------------------------------------------------------------
module ptrb_datapath #(
	parameter int BANK_DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ptrb_pkg::cmd_t                   cmd,
	output ptrb_pkg::sts_t                   sts,
	input  logic                             cfg_we,
	input  logic [ptrb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ptrb_pkg::DATA_W-1:0]      cfg_data,
	input  logic [ptrb_pkg::THREAD_W-1:0]    thread,
	input  logic [ptrb_pkg::DATA_W-1:0]      operand,
	output logic [ptrb_pkg::DATA_W-1:0]      reduced
);
	import ptrb_pkg::*;

	localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(BANK_DEPTH - 1);

	logic [OP_W-1:0]   op_select_q;
	logic [DATA_W-1:0] initial_value_q;
	logic [DATA_W-1:0] identity_value_q;

	logic [OP_W-1:0]     op_q;
	logic [DATA_W-1:0]   init_q;
	logic [DATA_W-1:0]   ident_q;
	logic [THREAD_W-1:0] thread_q;
	logic [DATA_W-1:0]   operand_q;

	logic [AW-1:0]     idx_q;
	logic [DATA_W-1:0] mem_q [BANK_DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] out_q;

	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] reload;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] comb_a;
	logic [DATA_W-1:0] comb_b;
	logic [DATA_W-1:0] comb_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_select_q      <= '0;
			initial_value_q  <= '0;
			identity_value_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OP_SELECT:      op_select_q      <= cfg_data[OP_W-1:0];
				CFG_INITIAL_VALUE:  initial_value_q  <= cfg_data;
				CFG_IDENTITY_VALUE: identity_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// operator and reload values are frozen per item
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q      <= op_select_q;
			init_q    <= initial_value_q;
			ident_q   <= identity_value_q;
			thread_q  <= thread;
			operand_q <= operand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	assign raddr  = cmd.rd_thread ? AW'(thread_q) : idx_q;
	assign waddr  = cmd.wr_thread ? AW'(thread_q) : idx_q;
	assign reload = (idx_q == '0) ? init_q : ident_q;

	always_comb begin
		case (cmd.wsel)
			WSEL_RELOAD: wdata = reload;
			WSEL_RESULT: wdata = comb_res;
			default:     wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem_q[waddr] <= wdata;
		end
		if (cmd.mem_re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign comb_a = cmd.collapse ? acc_q : rdata_q;
	assign comb_b = cmd.collapse ? rdata_q : operand_q;

	ptrb_combine u_combine (
		.clk (clk),
		.a   (comb_a),
		.b   (comb_b),
		.op  (op_q),
		.res (comb_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.acc_load_rd) begin
			acc_q <= rdata_q;
		end else if (cmd.acc_load_res) begin
			acc_q <= comb_res;
		end
		if (cmd.out_load) begin
			out_q <= acc_q;
		end
	end

	assign reduced       = out_q;
	assign sts.idx_zero  = (idx_q == '0);
	assign sts.idx_last  = (idx_q == LAST_IDX);
	assign sts.thread_ok = (int'(thread) < BANK_DEPTH);

endmodule

FILE: rtl/ptrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrb_ctrl
// Sequencer for clearing, bank loading, read-modify-write updates and the
// collapse walk; owns the input ready and the result valid.
// ----------------------------------------------------------------------------
module ptrb_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ptrb_pkg::KIND_W-1:0]   kind,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  ptrb_pkg::sts_t                sts,
	output ptrb_pkg::cmd_t                cmd
);
	import ptrb_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.idx_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_START:    state_d = ST_FILL;
						KIND_UPDATE:   state_d = sts.thread_ok ? ST_U_RD : ST_IDLE;
						KIND_COLLAPSE: state_d = ST_C_RD;
						default:       state_d = ST_IDLE;
					endcase
				end
			end
			ST_FILL: begin
				if (sts.idx_last) state_d = ST_IDLE;
			end
			ST_U_RD:   state_d = ST_U_WAIT;
			ST_U_WAIT: state_d = ST_U_WR;
			ST_U_WR:   state_d = ST_IDLE;
			ST_C_RD:   state_d = ST_C_WAIT;
			ST_C_WAIT: begin
				if (!sts.idx_zero) state_d = ST_C_EX;
				else if (sts.idx_last) state_d = ST_C_DONE;
				else state_d = ST_C_RD;
			end
			ST_C_EX: begin
				state_d = sts.idx_last ? ST_C_DONE : ST_C_RD;
			end
			ST_C_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.mem_we  = 1'b1;
				cmd.wsel    = WSEL_ZERO;
				cmd.idx_inc = !sts.idx_last;
			end
			ST_IDLE: begin
				cmd.latch   = accept;
				cmd.idx_clr = accept;
			end
			ST_FILL: begin
				cmd.mem_we  = 1'b1;
				cmd.wsel    = WSEL_RELOAD;
				cmd.idx_inc = !sts.idx_last;
			end
			ST_U_RD: begin
				cmd.mem_re    = 1'b1;
				cmd.rd_thread = 1'b1;
			end
			ST_U_WAIT: ;
			ST_U_WR: begin
				cmd.mem_we    = 1'b1;
				cmd.wr_thread = 1'b1;
				cmd.wsel      = WSEL_RESULT;
			end
			ST_C_RD: begin
				// entry is read out and reloaded in the same beat
				cmd.mem_re = 1'b1;
				cmd.mem_we = 1'b1;
				cmd.wsel   = WSEL_RELOAD;
			end
			ST_C_WAIT: begin
				cmd.collapse    = 1'b1;
				cmd.acc_load_rd = sts.idx_zero;
				cmd.idx_inc     = sts.idx_zero && !sts.idx_last;
			end
			ST_C_EX: begin
				cmd.collapse     = 1'b1;
				cmd.acc_load_res = 1'b1;
				cmd.idx_inc      = !sts.idx_last;
			end
			ST_C_DONE: begin
				cmd.out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/per_thread_reduction_bank_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_thread_reduction_bank_core
// Bank of per-thread 64-bit accumulators with start, update and collapse.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------
//   input    | in_valid / in_ready   | kind, thread, operand
//   result   | out_valid / out_ready | reduced
//   config   | cfg_we                | cfg_index, cfg_data
//
// update: a memory read, the registered fold step and the write back to
// the same entry; an ignored item leaves in_ready high.
// start: one memory write per entry.
// collapse: read plus fold per entry.
// after reset a clearing pass over every entry holds in_ready low.
// a waiting result only stalls the end of the next collapse.
// ----------------------------------------------------------------------------
module per_thread_reduction_bank_core #(
	parameter int BANK_DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ptrb_pkg::KIND_W-1:0]      kind,
	input  logic [ptrb_pkg::THREAD_W-1:0]    thread,
	input  logic [ptrb_pkg::DATA_W-1:0]      operand,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ptrb_pkg::DATA_W-1:0]      reduced,
	input  logic                             cfg_we,
	input  logic [ptrb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ptrb_pkg::DATA_W-1:0]      cfg_data
);
	import ptrb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ptrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ptrb_datapath #(
		.BANK_DEPTH (BANK_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thread    (thread),
		.operand   (operand),
		.reduced   (reduced)
	);

endmodule

FILE: rtl/ptrb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrb_checker
// Port-level checks on the reduction bank, bound to the top level.
// ----------------------------------------------------------------------------
module ptrb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [ptrb_pkg::KIND_W-1:0]    kind,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [ptrb_pkg::DATA_W-1:0]    reduced
);
	import ptrb_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reduced))
		else $error("result beat changed while stalled");

	// start and collapse always leave the bank busy after their beat is taken
	a_busy_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == KIND_START || kind == KIND_COLLAPSE)
		|=> !in_ready)
		else $error("ready right after a start or collapse beat");

	// an unused kind is dropped at once
	a_unused_kind: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_UNUSED |=> in_ready)
		else $error("unused kind stalled the input");

	// only collapse produces a result
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind != KIND_COLLAPSE |=> !$rose(out_valid))
		else $error("result raised by a non-collapse beat");

endmodule

bind per_thread_reduction_bank_core ptrb_checker u_ptrb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.kind      (kind),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.reduced   (reduced)
);

FILE: sim/tb_per_thread_reduction_bank_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_thread_reduction_bank_core
// Self-checking bench for the per-thread reduction bank. Start, update and
// collapse beats are mirrored into a software copy of the bank, and every
// collapse pushes its expected reduced value. Each result beat is checked in
// order against that list. Directed cases come first, then long random runs
// of start/update/collapse sequences, one run per operator code including two unused ones, under varying
// sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_per_thread_reduction_bank_core;
	import ptrb_pkg::*;

	localparam int BANK_DEPTH = 64;
	localparam int SETTLE_CYCLES = 4 * BANK_DEPTH + 16;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_ITEMS = 180;

	localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [KIND_W-1:0]    kind;
	logic [THREAD_W-1:0]  thread;
	logic [DATA_W-1:0]    operand;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [DATA_W-1:0]    reduced;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;

	// software copy of the bank and its registers
	logic [DATA_W-1:0] bank_model [BANK_DEPTH];
	logic [OP_W-1:0]   op_model;
	logic [DATA_W-1:0] init_model;
	logic [DATA_W-1:0] ident_model;
	logic [DATA_W-1:0] pending_reductions [$];

	int fail_count = 0;
	int cycle_count = 0;
	int hold_until = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	per_thread_reduction_bank_core #(
		.BANK_DEPTH(BANK_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.thread(thread),
		.operand(operand),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.reduced(reduced),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_per_thread_reduction_bank_core: FAIL");
			$finish;
		end
	end

	// result side: random stalls plus an optional long hold-off window
	always @(posedge clk) begin
		out_ready <= (cycle_count >= hold_until) && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_reductions.size() == 0) begin
				$error("reduced: expected none, actual %h", reduced);
				fail_count++;
			end else begin
				if (reduced !== pending_reductions[0]) begin
					$error("reduced: expected %h, actual %h", pending_reductions[0], reduced);
					fail_count++;
				end
				void'(pending_reductions.pop_front());
			end
		end
	end

	function automatic logic [DATA_W-1:0] fold_operands(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		case (op_model)
			OP_MUL:  return a * b;
			OP_OR:   return a | b;
			OP_AND:  return a & b;
			OP_XOR:  return a ^ b;
			OP_UMIN: return (a < b) ? a : b;
			OP_UMAX: return (a > b) ? a : b;
			OP_SMIN: return ($signed(a) < $signed(b)) ? a : b;
			OP_SMAX: return ($signed(a) > $signed(b)) ? a : b;
			default: return a + b;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_operand();
		case ($urandom_range(5))
			0: return 64'($urandom_range(15));
			1: return ~(64'h1 << $urandom_range(63));
			2: return {1'b1, 31'($urandom), $urandom};
			3: return $urandom_range(1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic reload_model();
		bank_model[0] = init_model;
		for (int i = 1; i < BANK_DEPTH; i++)
			bank_model[i] = ident_model;
	endtask

	task automatic model_item(input logic [KIND_W-1:0] k, input logic [THREAD_W-1:0] t,
			input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] acc;
		case (k)
			KIND_START: reload_model();
			KIND_UPDATE: begin
				if (t < BANK_DEPTH)
					bank_model[t] = fold_operands(bank_model[t], v);
			end
			KIND_COLLAPSE: begin
				acc = bank_model[0];
				for (int i = 1; i < BANK_DEPTH; i++)
					acc = fold_operands(acc, bank_model[i]);
				pending_reductions.push_back(acc);
				reload_model();
			end
			default: ;
		endcase
	endtask

	// valid stays high after the beat; the caller either offers the next one
	// or drains, which lowers it
	task automatic offer_item(input logic [KIND_W-1:0] k, input logic [THREAD_W-1:0] t,
			input logic [DATA_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		thread <= t;
		operand <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		model_item(k, t, v);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_reductions.size() != 0)
			@(posedge clk);
		// a start or update may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [DATA_W-1:0] op_word,
			input logic [DATA_W-1:0] init_word, input logic [DATA_W-1:0] ident_word);
		cfg_we <= 1'b1;
		cfg_index <= CFG_OP_SELECT;
		cfg_data <= op_word;
		@(posedge clk);
		op_model = op_word[OP_W-1:0];
		cfg_index <= CFG_INITIAL_VALUE;
		cfg_data <= init_word;
		@(posedge clk);
		init_model = init_word;
		cfg_index <= CFG_IDENTITY_VALUE;
		cfg_data <= ident_word;
		@(posedge clk);
		ident_model = ident_word;
		// unmapped index must leave everything alone
		cfg_index <= CFG_UNUSED;
		cfg_data <= {$urandom, $urandom};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_collapse();
		offer_item(KIND_COLLAPSE, '0, '0);
		offer_item(KIND_UNUSED, 6'd63, '1);
		drain_results();
	endtask

	task automatic test_add_extremes();
		set_config({60'h0, OP_ADD}, 64'h1, 64'h0);
		offer_item(KIND_START, '0, '0);
		offer_item(KIND_UPDATE, 6'd0, '1);
		offer_item(KIND_UPDATE, 6'd63, '1);
		offer_item(KIND_UPDATE, 6'd1, '0);
		offer_item(KIND_COLLAPSE, '0, '0);
		// second collapse sees the reloaded bank
		offer_item(KIND_COLLAPSE, '1, '1);
		drain_results();
	endtask

	task automatic test_unused_operator();
		set_config({60'hFFF_FFFF_FFFF_FFFF, OP_UNUSED_HI}, '1, 64'h1);
		offer_item(KIND_START, '0, '0);
		offer_item(KIND_UPDATE, 6'd63, 64'h1);
		offer_item(KIND_UPDATE, 6'd0, 64'h1);
		offer_item(KIND_COLLAPSE, '0, '0);
		drain_results();
	endtask

	task automatic test_operator_change();
		set_config({60'h0, OP_SMAX}, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
		offer_item(KIND_START, '0, '0);
		offer_item(KIND_UPDATE, 6'd5, 64'h7FFF_FFFF_FFFF_FFFF);
		offer_item(KIND_UPDATE, 6'd9, 64'hFFFF_FFFF_FFFF_FFFE);
		drain_results();
		// collapse folds with the operator in force now
		set_config({60'h0, OP_XOR}, 64'h0123_4567_89AB_CDEF, '0);
		offer_item(KIND_COLLAPSE, '0, '0);
		drain_results();
	endtask

	task automatic test_backpressure();
		set_config({60'h0, OP_ADD}, rand_operand(), rand_operand());
		idle_pct = 0;
		stall_pct <= 0;
		hold_until <= cycle_count + 800;
		offer_item(KIND_START, '0, '0);
		repeat (3) begin
			repeat (8) offer_item(KIND_UPDATE, 6'($urandom_range(63)), rand_operand());
			offer_item(KIND_COLLAPSE, '0, '0);
		end
		drain_results();
	endtask

	task automatic test_random_phase(input logic [OP_W-1:0] op_code, input int idle,
			input int stall);
		int sent;
		int nupd;
		int pick;
		logic [DATA_W-1:0] ident;
		case (op_code)
			OP_MUL:          ident = 64'h1;
			OP_AND, OP_UMIN: ident = '1;
			OP_SMIN:         ident = 64'h7FFF_FFFF_FFFF_FFFF;
			OP_SMAX:         ident = 64'h8000_0000_0000_0000;
			default:         ident = '0;
		endcase
		if ($urandom_range(1))
			ident = rand_operand();
		set_config({$urandom, 28'($urandom), op_code}, rand_operand(), ident);
		idle_pct = idle;
		stall_pct <= stall;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				offer_item(KIND_UNUSED, 6'($urandom), {$urandom, $urandom});
			end else if (pick < 10) begin
				// stray start or collapse outside a sequence
				offer_item((pick < 7) ? KIND_START : KIND_COLLAPSE, 6'($urandom), rand_operand());
				sent++;
			end else begin
				nupd = $urandom_range(2, 30);
				offer_item(KIND_START, 6'($urandom), rand_operand());
				repeat (nupd)
					offer_item(KIND_UPDATE, $urandom_range(1) ? 6'($urandom_range(63)) :
						6'($urandom_range(3)), rand_operand());
				offer_item(KIND_COLLAPSE, 6'($urandom), rand_operand());
				sent += nupd + 2;
			end
		end
		drain_results();
	endtask

	initial begin
		logic [OP_W-1:0] phase_ops [11];
		phase_ops = '{OP_ADD, OP_MUL, OP_OR, OP_AND, OP_XOR, OP_UMIN, OP_UMAX, OP_SMIN,
			OP_SMAX, OP_UNUSED_LO, OP_UNUSED_HI};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_START;
		thread <= '0;
		operand <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_OP_SELECT;
		cfg_data <= '0;
		op_model = OP_ADD;
		init_model = '0;
		ident_model = '0;
		for (int i = 0; i < BANK_DEPTH; i++)
			bank_model[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_collapse();
		test_add_extremes();
		test_unused_operator();
		test_operator_change();
		test_backpressure();
		for (int p = 0; p < 11; p++) begin
			case (p % 4)
				0: test_random_phase(phase_ops[p], 0, 0);
				1: test_random_phase(phase_ops[p], 77, 0);
				2: test_random_phase(phase_ops[p], 0, 77);
				default: test_random_phase(phase_ops[p], 11, 11);
			endcase
		end

		if (pending_reductions.size() != 0) begin
			$error("reduced: expected %0d more beats, actual none", pending_reductions.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("tb_per_thread_reduction_bank_core: PASS");
		else
			$display("tb_per_thread_reduction_bank_core: FAIL");
		$finish;
	end

endmodule

FILE: per_thread_reduction_bank_core.f
rtl/ptrb_pkg.sv
rtl/ptrb_combine.sv
rtl/ptrb_datapath.sv
rtl/ptrb_ctrl.sv
rtl/per_thread_reduction_bank_core.sv
rtl/ptrb_checker.sv
sim/tb_per_thread_reduction_bank_core.sv
